// ----- src/dual_valve_pulse_timer_controller_unit_assert.svh -----
// assertion macros for the dual valve pulse timer controller
// simulation builds get concurrent assertions, synthesis builds get nothing
`ifndef DUAL_VALVE_PULSE_TIMER_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_VALVE_PULSE_TIMER_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define DVPTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// condition must never be seen outside reset
`define DVPTC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define DVPTC_ASSERT(label, clk, rst_n, prop, msg)
`define DVPTC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- src/dvptc_pkg.sv -----
// shared types and constants for the dual valve pulse timer controller
// no dependencies
package dvptc_pkg;

    // operation code of one input transaction
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_EVENT = 1'b1
    } t_op;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_STYLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_MODE      = 1'b1;

    // width of the duration field on the result port
    localparam int DURATION_OUT_W = 6;

    // duration after reset, in steps (one second)
    localparam int DUR_RESET = 10;

    typedef struct packed {
        t_op  op;
        logic dispense_held;
        logic pick_held;
        logic step_up;
        logic step_down;
    } t_event;

    typedef struct packed {
        logic trigger_style;
        logic run_mode;
    } t_cfg;

    typedef struct packed {
        logic dispense;
        logic pick;
        logic active;
    } t_valves;

endpackage

// ----- src/dvptc_step.sv -----
// next-state logic for one transaction of the dual valve pulse timer controller
// depends on dvptc_pkg
module dvptc_step import dvptc_pkg::*; #(
    parameter int TICKS_PER_STEP = 100,
    parameter int MAX_DURATION   = 63,
    parameter int MS_W           = 7,
    parameter int DUR_W          = 6
) (
    input  t_event           i_event,
    input  t_cfg             i_cfg,
    input  t_valves          i_valves,
    input  logic [MS_W-1:0]  i_ms,
    input  logic [DUR_W-1:0] i_elapsed,
    input  logic [DUR_W-1:0] i_duration,
    output t_valves          o_valves,
    output logic [MS_W-1:0]  o_ms,
    output logic [DUR_W-1:0] o_elapsed,
    output logic [DUR_W-1:0] o_duration
);

    localparam logic [MS_W-1:0]  MS_LAST = MS_W'(TICKS_PER_STEP - 1);
    localparam logic [DUR_W-1:0] DUR_MAX = DUR_W'(MAX_DURATION);
    localparam logic [DUR_W-1:0] DUR_ONE = DUR_W'(1);

    logic           timed;
    logic           pulse;
    logic           restart;
    logic [DUR_W:0] elapsed_inc;
    t_valves        v;

    assign timed       = i_cfg.run_mode;
    assign pulse       = i_cfg.trigger_style;
    assign elapsed_inc = {1'b0, i_elapsed} + (DUR_W + 1)'(1);

    always_comb begin
        v          = i_valves;
        o_ms       = i_ms;
        o_elapsed  = i_elapsed;
        o_duration = i_duration;
        restart    = 1'b0;

        case (i_event.op)
            OP_TICK: begin
                if (i_valves.active) begin
                    if (i_ms == MS_LAST) begin
                        o_ms = '0;
                        if (elapsed_inc < {1'b0, i_duration}) begin
                            o_elapsed = elapsed_inc[DUR_W-1:0];
                        end else begin
                            v = '0;
                        end
                    end else begin
                        o_ms = i_ms + MS_W'(1);
                    end
                end
            end
            OP_EVENT: begin
                // encoder in timed mode: increase tried first; decrease when no increase is asked or already at the top
                if (timed) begin
                    if (i_event.step_up && (i_duration < DUR_MAX)) begin
                        o_duration = i_duration + DUR_ONE;
                    end else if (i_event.step_down && (i_duration > DUR_ONE)) begin
                        o_duration = i_duration - DUR_ONE;
                    end
                end

                // dispense button first
                if (i_event.dispense_held) begin
                    if (timed) begin
                        v.dispense = 1'b1;
                        v.pick     = 1'b0;
                        restart    = 1'b1;
                    end else if (pulse && v.dispense) begin
                        v.dispense = 1'b0;
                    end else begin
                        v.dispense = 1'b1;
                        v.pick     = 1'b0;
                    end
                end else if (!pulse && !timed) begin
                    v.dispense = 1'b0;
                end

                // pick-place button second, so it wins a double press
                if (i_event.pick_held) begin
                    if (timed) begin
                        v.dispense = 1'b0;
                        v.pick     = 1'b1;
                        restart    = 1'b1;
                    end else if (pulse && v.pick) begin
                        v.pick = 1'b0;
                    end else begin
                        v.dispense = 1'b0;
                        v.pick     = 1'b1;
                    end
                end else if (!pulse && !timed) begin
                    v.pick = 1'b0;
                end

                if (restart) begin
                    v.active  = 1'b1;
                    o_ms      = '0;
                    o_elapsed = '0;
                end
            end
            default: begin
                v = i_valves;
            end
        endcase

        o_valves = v;
    end

endmodule

// ----- src/dual_valve_pulse_timer_controller_unit.sv -----
// top level of the dual valve pulse timer controller
// depends on dvptc_pkg, dvptc_step and the assertion macro header
//
// One transaction per clock while the result side does not stall: a transaction
// enters an input register, and the step logic updates the valve, countdown and
// duration registers in one pass and loads the result register at the same clock
// edge, from which the result is offered on the output. The recurrence through
// the state registers is what sets the rate. A waiting result does not block
// intake: the input register keeps taking transactions until both the input and
// result registers are full and the downstream side stalls.
// Each transaction is a 1 ms tick or a user event; in timed mode a button press
// opens its valve, closes the other one and restarts a countdown of
// TICKS_PER_STEP ticks per step that closes both valves after the set duration.
// Configuration writes are expected only while the block is idle.
`include "dual_valve_pulse_timer_controller_unit_assert.svh"

module dual_valve_pulse_timer_controller_unit import dvptc_pkg::*; #(
    parameter int TICKS_PER_STEP = 100,
    parameter int MAX_DURATION   = 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic                      i_cfg_data,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_operation,
    input  logic                      i_dispense_held,
    input  logic                      i_pick_held,
    input  logic                      i_step_up,
    input  logic                      i_step_down,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_dispense_open,
    output logic                      o_pick_open,
    output logic                      o_countdown_running,
    output logic [DURATION_OUT_W-1:0] o_duration_steps
);

    // duration register must also hold the reset value when the top is small
    localparam int DUR_TOP = (MAX_DURATION > DUR_RESET) ? MAX_DURATION : DUR_RESET;
    localparam int DUR_W   = $clog2(DUR_TOP + 1);
    localparam int MS_W    = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;

    // configuration
    t_cfg r_cfg;

    // input register
    logic   r_in_valid;
    t_event r_in;

    // block state
    t_valves          r_valves;
    logic [MS_W-1:0]  r_ms;
    logic [DUR_W-1:0] r_elapsed;
    logic [DUR_W-1:0] r_duration;

    // next state from the step logic
    t_valves          n_valves;
    logic [MS_W-1:0]  n_ms;
    logic [DUR_W-1:0] n_elapsed;
    logic [DUR_W-1:0] n_duration;

    // result register
    logic                      r_out_valid;
    t_valves                   r_out_valves;
    logic [DURATION_OUT_W-1:0] r_out_duration;

    logic                            in_accept;
    logic                            advance;
    logic [DUR_W+DURATION_OUT_W-1:0] duration_ext;

    // step fires when a transaction waits and the result register is free or being emptied
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    // result carries the low bits of the duration
    assign duration_ext = {{DURATION_OUT_W{1'b0}}, n_duration};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TRIGGER_STYLE) begin
                r_cfg.trigger_style <= i_cfg_data;
            end
            if (i_cfg_index == CFG_RUN_MODE) begin
                r_cfg.run_mode <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op            <= t_op'(i_operation);
            r_in.dispense_held <= i_dispense_held;
            r_in.pick_held     <= i_pick_held;
            r_in.step_up       <= i_step_up;
            r_in.step_down     <= i_step_down;
        end
    end

    dvptc_step #(
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .MAX_DURATION   (MAX_DURATION),
        .MS_W           (MS_W),
        .DUR_W          (DUR_W)
    ) u_step (
        .i_event    (r_in),
        .i_cfg      (r_cfg),
        .i_valves   (r_valves),
        .i_ms       (r_ms),
        .i_elapsed  (r_elapsed),
        .i_duration (r_duration),
        .o_valves   (n_valves),
        .o_ms       (n_ms),
        .o_elapsed  (n_elapsed),
        .o_duration (n_duration)
    );

    // valve, countdown and duration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valves   <= '0;
            r_ms       <= '0;
            r_elapsed  <= '0;
            r_duration <= DUR_W'(DUR_RESET);
        end else if (advance) begin
            r_valves   <= n_valves;
            r_ms       <= n_ms;
            r_elapsed  <= n_elapsed;
            r_duration <= n_duration;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_valves   <= n_valves;
            r_out_duration <= duration_ext[DURATION_OUT_W-1:0];
        end
    end

    assign o_valid             = r_out_valid;
    assign o_dispense_open     = r_out_valves.dispense;
    assign o_pick_open         = r_out_valves.pick;
    assign o_countdown_running = r_out_valves.active;
    assign o_duration_steps    = r_out_duration;

    // the two valves are never driven open together
    `DVPTC_ASSERT_NEVER(a_valves_exclusive, i_clk, i_rst_n, r_valves.dispense && r_valves.pick, "both valves open")
    // tick counter wraps before reaching a full step
    `DVPTC_ASSERT(a_ms_range, i_clk, i_rst_n, r_ms <= MS_W'(TICKS_PER_STEP - 1), "tick count out of range")
    // duration never leaves its legal span
    `DVPTC_ASSERT(a_duration_range, i_clk, i_rst_n, (r_duration >= DUR_W'(1)) && (r_duration <= DUR_W'(DUR_TOP)), "duration out of range")
    // a stalled result is held, not dropped
    `DVPTC_ASSERT(a_result_held, i_clk, i_rst_n, (r_out_valid && i_stall) |=> r_out_valid, "stalled result lost")

endmodule

// ----- bench/tb.sv -----
// self-checking bench for dual_valve_pulse_timer_controller_unit
// a scoreboard class predicts every result, tasks drive transactions with random gaps and stalls
// depends on dvptc_pkg and the controller rtl
module tb import dvptc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_STEP = 100;
    localparam int MAX_DURATION   = 63;
    localparam int ITEM_TARGET    = 750;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        t_valves                   valves;
        logic [DURATION_OUT_W-1:0] steps;
    } t_result;

    // tracks valve, countdown and duration state and queues the predicted outputs
    class valve_tracker;
        t_cfg        cfg;
        logic        dispense_q;
        logic        pick_q;
        logic        running;
        int unsigned tick_count;
        int unsigned steps_done;
        int unsigned set_steps;
        t_result     expected_valves[$];
        int          errors;

        function new();
            cfg        = '0;
            dispense_q = 1'b0;
            pick_q     = 1'b0;
            running    = 1'b0;
            tick_count = 0;
            steps_done = 0;
            set_steps  = DUR_RESET;
            errors     = 0;
        endfunction

        function void restart();
            steps_done = 0;
            tick_count = 0;
            running    = 1'b1;
        endfunction

        function void advance(t_event ev);
            logic timed;
            logic pulse;
            timed = cfg.run_mode;
            pulse = cfg.trigger_style;
            if (ev.op == OP_TICK) begin
                // ticks only matter while a countdown runs
                if (running) begin
                    tick_count++;
                    if (tick_count >= TICKS_PER_STEP) begin
                        tick_count = 0;
                        if (steps_done + 1 < set_steps) begin
                            steps_done++;
                        end else begin
                            running    = 1'b0;
                            dispense_q = 1'b0;
                            pick_q     = 1'b0;
                        end
                    end
                end
                return;
            end
            // encoder, up wins when both detents come together and room is left
            if (timed && (ev.step_up || ev.step_down)) begin
                if (ev.step_up && set_steps < MAX_DURATION) begin
                    set_steps++;
                end else if (ev.step_down && set_steps > 1) begin
                    set_steps--;
                end
            end
            if (ev.dispense_held) begin
                if (timed) begin
                    dispense_q = 1'b1;
                    pick_q     = 1'b0;
                    restart();
                end else if (pulse && dispense_q) begin
                    dispense_q = 1'b0;
                end else begin
                    dispense_q = 1'b1;
                    pick_q     = 1'b0;
                end
            end else if (!pulse && !timed) begin
                dispense_q = 1'b0;
            end
            // pick-place handled second so it wins a double press
            if (ev.pick_held) begin
                if (timed) begin
                    dispense_q = 1'b0;
                    pick_q     = 1'b1;
                    restart();
                end else if (pulse && pick_q) begin
                    pick_q = 1'b0;
                end else begin
                    dispense_q = 1'b0;
                    pick_q     = 1'b1;
                end
            end else if (!pulse && !timed) begin
                pick_q = 1'b0;
            end
        endfunction

        function void note_item(t_event ev);
            t_result want;
            advance(ev);
            want.valves.dispense = dispense_q;
            want.valves.pick     = pick_q;
            want.valves.active   = running;
            want.steps           = set_steps[DURATION_OUT_W-1:0];
            expected_valves.push_back(want);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_valves.size() == 0) begin
                flag_mismatch("result with no transaction outstanding");
                return;
            end
            want = expected_valves.pop_front();
            if (got.valves.dispense !== want.valves.dispense)
                flag_mismatch($sformatf("dispense_open got %0b want %0b",
                                        got.valves.dispense, want.valves.dispense));
            if (got.valves.pick !== want.valves.pick)
                flag_mismatch($sformatf("pick_open got %0b want %0b",
                                        got.valves.pick, want.valves.pick));
            if (got.valves.active !== want.valves.active)
                flag_mismatch($sformatf("countdown_running got %0b want %0b",
                                        got.valves.active, want.valves.active));
            if (got.steps !== want.steps)
                flag_mismatch($sformatf("duration_steps got %0d want %0d",
                                        got.steps, want.steps));
        endtask
    endclass

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index  = '0;
    logic                      cfg_data   = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    t_event                    in_item    = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic                      out_dispense;
    logic                      out_pick;
    logic                      out_running;
    logic [DURATION_OUT_W-1:0] out_steps;

    valve_tracker tracker = new();
    t_result      seen_result;
    int unsigned  items_done    = 0;
    int unsigned  idle_cycles   = 0;
    bit           quiet_stretch = 1'b0;
    int unsigned  stall_left    = 0;
    int unsigned  calm_left     = 0;
    int unsigned  stall_roll;

    dual_valve_pulse_timer_controller_unit #(
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .MAX_DURATION   (MAX_DURATION)
    ) u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_valid             (in_valid),
        .o_stall             (in_stall),
        .i_operation         (in_item.op),
        .i_dispense_held     (in_item.dispense_held),
        .i_pick_held         (in_item.pick_held),
        .i_step_up           (in_item.step_up),
        .i_step_down         (in_item.step_down),
        .o_valid             (out_valid),
        .i_stall             (out_stall),
        .o_dispense_open     (out_dispense),
        .o_pick_open         (out_pick),
        .o_countdown_running (out_running),
        .o_duration_steps    (out_steps)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // result side back-pressure: mostly free cycles and short stalls, some long stalls, some calm stretches
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (calm_left != 0) begin
            calm_left <= calm_left - 1;
            out_stall <= 1'b0;
        end else begin
            stall_roll = $urandom_range(99);
            if (stall_roll < 55) begin
                out_stall <= 1'b0;
            end else if (stall_roll < 85) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(2);
            end else if (stall_roll < 95) begin
                out_stall <= 1'b0;
                calm_left <= $urandom_range(80, 20);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(40, 10);
            end
        end
    end

    // every accepted result is compared with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen_result = {out_dispense, out_pick, out_running, out_steps};
            tracker.check_result(seen_result);
        end
    end

    // cycles without any transaction on either side or a register write
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_stretch)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic t_event make_event(logic d, logic p, logic up, logic dn);
        t_event ev;
        ev.op            = OP_EVENT;
        ev.dispense_held = d;
        ev.pick_held     = p;
        ev.step_up       = up;
        ev.step_down     = dn;
        return ev;
    endfunction

    // tick with random button and encoder bits, which the block must ignore
    function automatic t_event make_tick();
        t_event ev;
        ev.op = OP_TICK;
        {ev.dispense_held, ev.pick_held, ev.step_up, ev.step_down} = 4'($urandom_range(15));
        return ev;
    endfunction

    function automatic t_event any_item();
        t_event ev;
        ev    = make_tick();
        ev.op = t_op'(1'($urandom_range(1)));
        return ev;
    endfunction

    // one input transaction, valid stays high afterwards unless the next call idles
    task automatic send(t_event ev);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (in_stall);
        if (ev.op == OP_EVENT || tracker.running)
            items_done++;
        tracker.note_item(ev);
    endtask

    // wait until every predicted result has been seen and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_valves.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TRIGGER_STYLE)
            tracker.cfg.trigger_style = value;
        else
            tracker.cfg.run_mode = value;
        @(posedge clk);
    endtask

    // encoder detents until the duration reaches the target, needs timed mode
    task automatic walk_duration(int unsigned target);
        int unsigned guard;
        logic        up;
        logic        both;
        guard = 0;
        while (tracker.set_steps != target && guard < 2 * MAX_DURATION) begin
            up   = (tracker.set_steps < target);
            both = up && ($urandom_range(9) == 0);
            send(make_event($urandom_range(19) == 0, $urandom_range(19) == 0,
                            up || both, !up || both));
            guard++;
        end
    endtask

    // buttons held and released in runs, encoder bits sprinkled in
    task automatic button_play(int unsigned count);
        logic d;
        logic p;
        d = 1'($urandom_range(1));
        p = 1'($urandom_range(1));
        repeat (count) begin
            if ($urandom_range(9) < 3)
                d = ~d;
            if ($urandom_range(9) < 3)
                p = ~p;
            send(make_event(d, p, $urandom_range(9) == 0, $urandom_range(9) == 0));
        end
    endtask

    // press and tick through a countdown, in trigger mode drain a leftover one
    task automatic run_countdown();
        int unsigned budget;
        logic [1:0]  which;
        if (tracker.cfg.run_mode) begin
            if (tracker.set_steps > 3)
                walk_duration($urandom_range(3, 1));
            which = 2'($urandom_range(3, 1));
            send(make_event(which[1], which[0], 1'b0, 1'b0));
            if ($urandom_range(4) != 0)
                budget = TICKS_PER_STEP * tracker.set_steps + $urandom_range(8);
            else
                budget = $urandom_range(TICKS_PER_STEP * tracker.set_steps, 1);
        end else if (tracker.running) begin
            budget = 4 * TICKS_PER_STEP;
        end else begin
            button_play(6);
            return;
        end
        while (budget != 0) begin
            if ($urandom_range(49) == 0)
                send(any_item());
            else
                send(make_tick());
            budget--;
            // a few ignored ticks after expiry, then move on
            if (!tracker.running && budget > 3)
                budget = 3;
        end
    endtask

    initial begin
        t_event      ev;
        int unsigned phase;
        int unsigned roll;
        int unsigned target;
        logic [1:0]  mode_style;
        bit          swept;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // permanent style, trigger mode straight after reset
        ev    = make_event(1'b1, 1'b1, 1'b1, 1'b1);
        ev.op = OP_TICK;
        send(ev);                                      // tick with no countdown
        send(make_event(1'b1, 1'b0, 1'b0, 1'b0));
        send(make_event(1'b0, 1'b1, 1'b1, 1'b1));      // encoder ignored here
        send(make_event(1'b1, 1'b1, 1'b0, 1'b0));      // double press
        send(make_event(1'b0, 1'b0, 1'b0, 1'b0));
        settle();

        // pulse style toggling
        write_reg(CFG_TRIGGER_STYLE, 1'b1);
        send(make_event(1'b1, 1'b0, 1'b0, 1'b0));
        send(make_event(1'b1, 1'b0, 1'b1, 1'b0));
        send(make_event(1'b0, 1'b0, 1'b0, 1'b0));
        send(make_event(1'b1, 1'b1, 1'b0, 1'b0));
        send(make_event(1'b0, 1'b1, 1'b0, 1'b0));
        send(make_event(1'b1, 1'b1, 1'b0, 1'b0));
        settle();

        // timed mode, permanent style: encoder, start, release, restart
        write_reg(CFG_RUN_MODE, 1'b1);
        write_reg(CFG_TRIGGER_STYLE, 1'b0);
        send(make_event(1'b0, 1'b0, 1'b1, 1'b1));
        send(make_event(1'b0, 1'b0, 1'b0, 1'b1));
        send(make_event(1'b1, 1'b0, 1'b0, 1'b1));
        send(make_event(1'b0, 1'b0, 1'b0, 1'b0));      // release keeps valve open
        send(make_tick());
        send(make_event(1'b0, 1'b1, 1'b1, 1'b0));
        send(ev);
        send(make_event(1'b1, 1'b1, 1'b0, 1'b0));

        // random phases, each under its own register setting
        swept = 1'b0;
        phase = 2;
        while (items_done < ITEM_TARGET) begin
            settle();
            if ($urandom_range(3) == 0)
                mode_style = 2'($urandom_range(3));
            else
                mode_style = phase[1:0];
            write_reg(CFG_RUN_MODE, mode_style[1]);
            write_reg(CFG_TRIGGER_STYLE, mode_style[0]);
            quiet_stretch = ($urandom_range(3) == 0);

            // once: full duration range with both limits and double detents
            if (mode_style[1] && !swept) begin
                walk_duration(MAX_DURATION);
                send(make_event(1'b0, 1'b0, 1'b1, 1'b0));
                send(make_event(1'b0, 1'b0, 1'b1, 1'b1));
                walk_duration(1);
                send(make_event(1'b0, 1'b0, 1'b0, 1'b1));
                swept = 1'b1;
            end

            repeat ($urandom_range(5, 2)) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    run_countdown();
                end else if (roll < 65 && mode_style[1]) begin
                    roll = $urandom_range(3);
                    if (roll == 0)
                        target = 1;
                    else if (roll == 1)
                        target = MAX_DURATION;
                    else
                        target = $urandom_range(MAX_DURATION, 1);
                    walk_duration(target);
                end else if (roll < 85) begin
                    button_play($urandom_range(12, 4));
                end else begin
                    repeat ($urandom_range(10, 3)) send(any_item());
                end
            end
            phase++;
        end

        settle();
        if (tracker.errors == 0 && tracker.expected_valves.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
